### design/pfa_pkg.sv
// pfa_pkg: shared constants, token and state types for the page frame allocator.
// No dependencies.
package pfa_pkg;

  localparam int unsigned NUM_PAGES = 64;
  localparam int unsigned CNT_W     = $clog2(NUM_PAGES + 1);
  localparam int unsigned PID_W     = 8;
  localparam int unsigned BLK_W     = 16;
  localparam int unsigned PS_W      = 11;
  localparam int unsigned OUT_W     = 7;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_CLAIM,
    OP_FREE
  } pfa_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_COUNT,
    ST_CLAIM,
    ST_FREE
  } pfa_state_e;

  // item walking down the page chain
  typedef struct packed {
    logic             vld;
    pfa_op_e          op;
    logic [PID_W-1:0] pid;
    logic [CNT_W-1:0] cnt;
  } pfa_tok_t;

endpackage

### design/pfa_cell.sv
// pfa_cell: one page of the chain; holds used bit and owner, applies the passing token.
// Depends on pfa_pkg.
module pfa_cell import pfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pfa_tok_t tok_i,
  output pfa_tok_t tok_o
);

  logic             used_q, used_d;
  logic [PID_W-1:0] owner_q;
  logic             own_we;
  pfa_tok_t         tok_q, tok_d;

  always_comb begin
    tok_d  = tok_i;
    used_d = used_q;
    own_we = 1'b0;
    if (tok_i.vld) begin
      case (tok_i.op)
        OP_COUNT: begin
          if (!used_q) tok_d.cnt = tok_i.cnt + CNT_W'(1);
        end
        OP_CLAIM: begin
          if (!used_q && (tok_i.cnt != '0)) begin
            used_d    = 1'b1;
            own_we    = 1'b1;
            tok_d.cnt = tok_i.cnt - CNT_W'(1);
          end
        end
        OP_FREE: begin
          if (used_q && (owner_q == tok_i.pid)) begin
            used_d    = 1'b0;
            tok_d.cnt = tok_i.cnt + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      used_q <= used_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (own_we) owner_q <= tok_i.pid;
  end

  assign tok_o = tok_q;

endmodule

### design/pfa_div.sv
// pfa_div: restoring divider, one quotient bit per cycle; returns ceil(dividend / divisor).
// Depends on pfa_pkg.
module pfa_div import pfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [BLK_W-1:0] dividend_i,
  input  logic [PS_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [BLK_W-1:0] need_o
);

  localparam int unsigned STEP_W = $clog2(BLK_W);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PS_W-1:0]   dvs_q, rem_q, rem_d;
  logic [BLK_W-1:0]  quo_q, quo_d;
  logic [PS_W:0]     trial;

  // trial stays below twice the divisor, so it fits PS_W+1 bits
  assign trial = {rem_q, quo_q[BLK_W-1]};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = PS_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[BLK_W-2:0], 1'b1};
      end else begin
        rem_d = trial[PS_W-1:0];
        quo_d = {quo_q[BLK_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(BLK_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    if (start_i) dvs_q <= (divisor_i == '0) ? PS_W'(1) : divisor_i;
  end

  // ceiling: round up on a nonzero remainder; cannot wrap (divisor 1 leaves no remainder)
  assign done_o = done_q;
  assign need_o = quo_q + BLK_W'(rem_q != '0);

endmodule

### design/page_frame_allocator.sv
// page_frame_allocator: top level; request control, divider and the chain of page cells.
// Depends on pfa_pkg, pfa_div, pfa_cell.
// Unload sends a free token down the chain. Load runs the divide, then a count pass, then a
// claim pass; it ends after the divide on a zero need and after the count pass when refused.
// One item at a time; next start taken as the result shows; receiver cannot stall.
// Reset: pages free.
module page_frame_allocator import pfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request channel
  input  logic             start,
  output logic             busy,
  input  logic             mode_i,
  input  logic [PID_W-1:0] pid_i,
  input  logic [BLK_W-1:0] block_count_i,
  // page size register write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [PS_W-1:0]  cfg_data_i,
  // result
  output logic             done_o,
  output logic             ok_o,
  output logic [OUT_W-1:0] pages_changed_o,
  output logic [OUT_W-1:0] pages_in_use_o
);

  pfa_state_e       state_q, state_d;
  logic [PS_W-1:0]  page_size_q;
  logic [PID_W-1:0] pid_q;
  logic [BLK_W-1:0] need_q;
  logic [CNT_W-1:0] total_q, total_d;
  logic             done_q, ok_q, ok_d, res_we;
  logic [CNT_W-1:0] chg_q, chg_d;

  logic             accept;
  logic             div_done;
  logic [BLK_W-1:0] div_need;

  pfa_tok_t         tok [NUM_PAGES+1];
  pfa_tok_t         head;
  pfa_tok_t         tail;
  logic [NUM_PAGES-1:0] tok_vld;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign tok[0]      = head;
  assign tail        = tok[NUM_PAGES];

  // ceil(block_count / page_size), page size 0 handled as 1 inside
  pfa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && !mode_i),
    .dividend_i (block_count_i),
    .divisor_i  (page_size_q),
    .done_o     (div_done),
    .need_o     (div_need)
  );

  // page chain: cell i holds page i; a token visits pages in ascending order
  for (genvar g = 0; g < NUM_PAGES; g++) begin : g_cell
    pfa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
    assign tok_vld[g] = tok[g+1].vld;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = mode_i ? ST_FREE : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = (div_need == '0) ? ST_IDLE : ST_COUNT;
      end
      ST_COUNT: begin
        if (tail.vld) state_d = (need_q > BLK_W'(tail.cnt)) ? ST_IDLE : ST_CLAIM;
      end
      ST_CLAIM, ST_FREE: begin
        if (tail.vld) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // token injection, result and in-use total
  always_comb begin
    head    = '{vld: 1'b0, op: OP_COUNT, pid: pid_q, cnt: '0};
    res_we  = 1'b0;
    ok_d    = 1'b0;
    chg_d   = '0;
    total_d = total_q;
    case (state_q)
      ST_IDLE: begin
        // unload goes straight down the chain
        if (accept && mode_i) head = '{vld: 1'b1, op: OP_FREE, pid: pid_i, cnt: '0};
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_need == '0) begin
            res_we = 1'b1;
            ok_d   = 1'b1;
          end else begin
            head = '{vld: 1'b1, op: OP_COUNT, pid: pid_q, cnt: '0};
          end
        end
      end
      ST_COUNT: begin
        if (tail.vld) begin
          if (need_q > BLK_W'(tail.cnt)) begin
            res_we = 1'b1; // refused, nothing changes
          end else begin
            // need fits the count width here since it is at most the free count
            head = '{vld: 1'b1, op: OP_CLAIM, pid: pid_q, cnt: CNT_W'(need_q)};
          end
        end
      end
      ST_CLAIM: begin
        if (tail.vld) begin
          res_we  = 1'b1;
          ok_d    = 1'b1;
          chg_d   = CNT_W'(need_q);
          total_d = total_q + CNT_W'(need_q);
        end
      end
      ST_FREE: begin
        if (tail.vld) begin
          res_we  = 1'b1;
          ok_d    = (tail.cnt != '0);
          chg_d   = tail.cnt;
          total_d = total_q - tail.cnt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      page_size_q <= PS_W'(4);
      total_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      done_q  <= res_we;
      if (cfg_valid_i && cfg_ready_o) page_size_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) pid_q <= pid_i;
    if (state_q == ST_DIV && div_done) need_q <= div_need;
    if (res_we) begin
      ok_q  <= ok_d;
      chg_q <= chg_d;
    end
  end

  // counts are reported modulo 2^7
  assign done_o          = done_q;
  assign ok_o            = ok_q;
  assign pages_changed_o = OUT_W'(chg_q);
  assign pages_in_use_o  = OUT_W'(total_q);

  // result strobe only appears once the request has fully retired
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while a request is still in flight");

  // never more pages in use than exist
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(NUM_PAGES))
    else $error("in-use total exceeds page count");

  // at most one token travels the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one token in the page chain");

  // a token leaves the chain only while a pass is outstanding
  a_tail_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> (state_q == ST_COUNT || state_q == ST_CLAIM || state_q == ST_FREE))
    else $error("token left the chain with no pass pending");

endmodule
